### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DTAV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DTAV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/dtav_pkg.sv
// ----------------------------------------------------------------------------
// dtav_pkg
// types and constants shared by the decaying token activation vector
// ----------------------------------------------------------------------------
`default_nettype none

package dtav_pkg;

	// default number of token entries
	localparam int DTAV_DIM = 64;

	// field widths
	localparam int ACT_W   = 17;
	localparam int AMT_W   = 16;
	localparam int SIZE_W  = 7;
	localparam int TOK_W   = 8;
	localparam int IDX_W   = 6;
	localparam int CMD_W   = 2;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 16;

	// q1.16 constants
	localparam logic [ACT_W-1:0] ACT_ONE  = 17'h10000;
	localparam logic [ACT_W-1:0] ACT_ZERO = 17'h00000;

	// commands
	localparam logic [CMD_W-1:0] CMD_DECAY_SET = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET       = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_DECAY_MODE   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_DECAY_AMOUNT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_ACTIVE_SIZE  = 2'd2;

	// register reset values
	localparam logic              RST_DECAY_MODE   = 1'b0;
	localparam logic [AMT_W-1:0]  RST_DECAY_AMOUNT = 16'd6554;
	localparam logic [SIZE_W-1:0] RST_ACTIVE_SIZE  = 7'd64;

	// decay modes
	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_EXP    = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [TOK_W-1:0] token;
	} dtav_in_t;

	typedef struct packed {
		logic [IDX_W-1:0] entry_index;
		logic [ACT_W-1:0] activation;
		logic             last;
		logic             range_error;
	} dtav_out_t;

endpackage

`default_nettype wire

### design/dtav_mem.sv
// ----------------------------------------------------------------------------
// dtav_mem
// activation store, one write and one registered read port, per-entry
// valid bits so that unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
`default_nettype none

module dtav_mem
	import dtav_pkg::*;
#(
	parameter int DEPTH = DTAV_DIM
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        wr_en,
	input  wire [$clog2(DEPTH)-1:0]    wr_addr,
	input  wire [ACT_W-1:0]            wr_data,
	input  wire                        rd_en,
	input  wire [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [ACT_W-1:0]           rd_data
);

	logic [ACT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [ACT_W-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : ACT_ZERO;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/dtav_decay.sv
// ----------------------------------------------------------------------------
// dtav_decay
// shared decay unit: linear subtract with floor at zero, or q0.16 multiply
// ----------------------------------------------------------------------------
`default_nettype none

module dtav_decay
	import dtav_pkg::*;
(
	input  wire              mode,
	input  wire [AMT_W-1:0]  amount,
	input  wire [ACT_W-1:0]  act_in,
	output logic [ACT_W-1:0] act_out
);

	logic [ACT_W+AMT_W-1:0] prod;
	logic [ACT_W-1:0]       amt_ext;

	assign amt_ext = ACT_W'(amount);
	assign prod    = (ACT_W+AMT_W)'(act_in) * (ACT_W+AMT_W)'(amount);

	always_comb begin
		if (mode == MODE_EXP) begin
			// truncate toward zero
			act_out = prod[ACT_W+AMT_W-1:AMT_W];
		end else begin
			act_out = (act_in > amt_ext) ? ACT_W'(act_in - amt_ext) : ACT_ZERO;
		end
	end

endmodule

`default_nettype wire

### design/decaying_token_activation_vector_top.sv
// ----------------------------------------------------------------------------
// decaying_token_activation_vector_top
// per-token activation vector with linear or exponential decay
// ----------------------------------------------------------------------------
// The block keeps DIM unsigned q1.16 activations (0x10000 is 1.0), all zero
// after reset. An input word carries a command and a token. Command 0 decays
// every entry in use and then sets the token's entry to 1.0; command 1 sets the
// entry without decay; command 2 streams out every entry in use, one output
// word per entry, with last on the final one. A token at or beyond the active
// size gives one output word with range_error set and activation zero, and the
// entry is left alone (the decay of command 0 still runs). Command 3 is
// dropped. Entries beyond the active size keep their values. The decay pass
// is set by the single read port of the activation memory, one entry per
// cycle through the shared decay unit; read-out takes a memory read and then
// the output load for each entry, and waits while the output is stalled.
// The input stall is high whenever an item is in progress. Config writes are
// always taken (cfg_ready tied high) and must be made while the block is idle.
// There is no clearing pass after reset: per-entry valid bits give zero.
// ----------------------------------------------------------------------------
`default_nettype none

module decaying_token_activation_vector_top
	import dtav_pkg::*;
#(
	parameter int DIM = DTAV_DIM
) (
	input  wire                 clk,
	input  wire                 arst_n,
	// input words
	input  wire                 in_valid,
	output logic                in_stall,
	input  dtav_in_t            in_data,
	// output words
	output logic                out_valid,
	input  wire                 out_stall,
	output dtav_out_t           out_data,
	// config writes
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [CFG_IW-1:0]    cfg_index,
	input  wire [CFG_DW-1:0]    cfg_data
);

	localparam int AW = $clog2(DIM);
	localparam int CW = $clog2(DIM + 1);

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_DECAY    = 5'b00010,
		ST_SET      = 5'b00100,
		ST_RD_ISSUE = 5'b01000,
		ST_RD_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	// config registers
	logic              mode_q;
	logic [AMT_W-1:0]  amount_q;
	logic [SIZE_W-1:0] size_q;

	// current item
	logic [TOK_W-1:0]  tok_q;
	logic [CW-1:0]     cnt_q;

	// decay pipeline, read issued in one cycle, written back the next
	logic              vld_s1;
	logic [AW-1:0]     addr_s1;

	// output register
	logic              out_valid_q;
	dtav_out_t         out_q;

	// memory ports
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [ACT_W-1:0]  wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [ACT_W-1:0]  rd_data;
	logic [ACT_W-1:0]  decayed;

	logic [CW-1:0]     n_used;
	logic              in_acc;
	logic              out_free;
	logic              tok_err;
	logic              dec_issue;
	logic              rd_last;

	// entries in use: zero counts as one, anything above DIM as DIM
	always_comb begin
		if (size_q == '0) begin
			n_used = CW'(1);
		end else if (size_q > SIZE_W'(DIM)) begin
			n_used = CW'(DIM);
		end else begin
			n_used = CW'(size_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign tok_err   = (tok_q >= TOK_W'(n_used));
	assign dec_issue = (state_q == ST_DECAY) && (cnt_q < n_used);
	assign rd_last   = (CW'(cnt_q + CW'(1)) == n_used);

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= RST_DECAY_MODE;
			amount_q <= RST_DECAY_AMOUNT;
			size_q   <= RST_ACTIVE_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DECAY_MODE:   mode_q   <= cfg_data[0];
				CFG_DECAY_AMOUNT: amount_q <= cfg_data[AMT_W-1:0];
				CFG_ACTIVE_SIZE:  size_q   <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = decayed;
		case (state_q)
			ST_DECAY: begin
				rd_en = dec_issue;
				wr_en = vld_s1;
			end
			ST_SET: begin
				// token write happens with the output load, exactly once, unless the token is out of range
				wr_en   = out_free && !tok_err;
				wr_addr = tok_q[AW-1:0];
				wr_data = ACT_ONE;
			end
			ST_RD_ISSUE: begin
				rd_en = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= dec_issue;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						case (in_data.command)
							CMD_DECAY_SET: state_q <= ST_DECAY;
							CMD_SET:       state_q <= ST_SET;
							CMD_READ:      state_q <= ST_RD_ISSUE;
							default:       state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DECAY: begin
					if (dec_issue) begin
						cnt_q <= CW'(cnt_q + CW'(1));
					end else if (!vld_s1) begin
						// last write-back done
						state_q <= ST_SET;
					end
				end
				ST_SET: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_EMIT;
				end
				ST_RD_EMIT: begin
					if (out_free) begin
						cnt_q   <= CW'(cnt_q + CW'(1));
						state_q <= rd_last ? ST_IDLE : ST_RD_ISSUE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and decay address pipeline
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tok_q <= in_data.token;
		end
		addr_s1 <= cnt_q[AW-1:0];
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && ((state_q == ST_SET) || (state_q == ST_RD_EMIT))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_SET) begin
				out_q.entry_index <= tok_q[IDX_W-1:0];
				out_q.activation  <= tok_err ? ACT_ZERO : ACT_ONE;
				out_q.last        <= 1'b1;
				out_q.range_error <= tok_err;
			end else if (state_q == ST_RD_EMIT) begin
				out_q.entry_index <= IDX_W'(cnt_q);
				out_q.activation  <= rd_data;
				out_q.last        <= rd_last;
				out_q.range_error <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	dtav_mem #(
		.DEPTH   (DIM)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// the one shared decay unit
	dtav_decay u_decay (
		.mode    (mode_q),
		.amount  (amount_q),
		.act_in  (rd_data),
		.act_out (decayed)
	);

endmodule

`default_nettype wire

### design/dtav_checker.sv
// ----------------------------------------------------------------------------
// dtav_checker
// port-level checks on the output words of the activation vector
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dtav_checker
	import dtav_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_stall,
	input dtav_out_t out_data
);

	// a stalled output word holds
	`DTAV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "output word changed while stalled")

	// a range error word is a final word (last set)
	`DTAV_ASSERT(a_err_last, clk, arst_n, !out_valid || !out_data.range_error || out_data.last, "range error without last")

	// a range error carries no activation
	`DTAV_ASSERT(a_err_zero, clk, arst_n, !out_valid || !out_data.range_error || (out_data.activation == ACT_ZERO), "range error with nonzero activation")

	// activations never exceed 1.0
	`DTAV_ASSERT(a_act_max, clk, arst_n, !out_valid || (out_data.activation <= ACT_ONE), "activation above 1.0")

endmodule

bind decaying_token_activation_vector_top dtav_checker u_dtav_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
